// ----- rtl/bmpc_pkg.sv -----
package bmpc_pkg;

    localparam int CHANNEL_BITS_DEFAULT = 16;
    localparam int CFG_ADDR_BITS = 1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_LAYER_OPACITY = 1'b0,
        REG_MASK_ENABLE   = 1'b1
    } cfg_reg_t;

endpackage

// ----- rtl/bmpc_alpha.sv -----
module bmpc_alpha #(
    parameter int CHANNEL_BITS = bmpc_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [CHANNEL_BITS-1:0] layer_opacity,
    input  logic                    mask_enable,
    input  logic [CHANNEL_BITS-1:0] base_alpha,
    input  logic [CHANNEL_BITS-1:0] layer_alpha,
    input  logic [CHANNEL_BITS-1:0] mask_sample,
    output logic [CHANNEL_BITS-1:0] lw,
    output logic [CHANNEL_BITS-1:0] oa
);
    import bmpc_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam logic [N-1:0] FULL = {N{1'b1}};
    localparam logic [2*N-1:0] HALF = {1'b0, {(2*N-1){1'b0}}} | (2*N)'(FULL >> 1);

    // rounded divide by all-ones: x = hi*2^N + lo = hi*FULL + (hi + lo)
    function automatic logic [N-1:0] fx_norm(input logic [2*N-1:0] p);
        logic [2*N-1:0] x;
        logic [N:0]     s;
        logic [N:0]     q;
        begin
            x = p + HALF;
            s = {1'b0, x[2*N-1:N]} + {1'b0, x[N-1:0]};
            q = {1'b0, x[2*N-1:N]};
            if (s >= {1'b0, FULL}) begin
                q = q + 1'b1;
            end
            if (s >= {FULL, 1'b0}) begin
                q = q + 1'b1;
            end
            fx_norm = q[N-1:0];
        end
    endfunction

    logic [2*N-1:0] p1_reg, p2_reg, p3_reg;
    logic [N-1:0]   opac1_reg, ba1_reg, la1_reg, ba2_reg, ba3_reg;
    logic           men1_reg;
    logic [N-1:0]   lw_reg, oa_reg;
    logic [N-1:0]   eff;
    logic [N-1:0]   lw_next;
    logic [N:0]     oa_sum;

    assign eff     = men1_reg ? fx_norm(p1_reg) : opac1_reg;
    assign lw_next = fx_norm(p3_reg);
    assign oa_sum  = {1'b0, ba3_reg} + {1'b0, lw_next};

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= layer_opacity * mask_sample;
            opac1_reg <= layer_opacity;
            men1_reg  <= mask_enable;
            ba1_reg   <= base_alpha;
            la1_reg   <= layer_alpha;
            p2_reg    <= la1_reg * eff;
            ba2_reg   <= ba1_reg;
            p3_reg    <= (FULL - ba2_reg) * fx_norm(p2_reg);
            ba3_reg   <= ba2_reg;
            lw_reg    <= lw_next;
            oa_reg    <= oa_sum[N-1:0];
        end
    end

    assign lw = lw_reg;
    assign oa = oa_reg;

endmodule

// ----- rtl/bmpc_lane.sv -----
module bmpc_lane #(
    parameter int CHANNEL_BITS = bmpc_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [CHANNEL_BITS-1:0] base_c,
    input  logic [CHANNEL_BITS-1:0] base_a,
    input  logic [CHANNEL_BITS-1:0] layer_c,
    input  logic [CHANNEL_BITS-1:0] lw,
    input  logic [CHANNEL_BITS-1:0] oa,
    output logic [CHANNEL_BITS-1:0] color
);
    localparam int N = CHANNEL_BITS;

    logic [2*N-1:0] pb_reg, pl_reg;
    logic [N-1:0]   oa_a_reg, oa_b_reg;
    logic [2*N-1:0] num_reg;
    logic [2*N:0]   num_sum;

    logic [N-1:0] rem_reg [N];
    logic [N-1:0] low_reg [N];
    logic [N-1:0] quo_reg [N];
    logic [N-1:0] div_reg [N];

    // numerator stays below oa * 2^N, so N quotient bits suffice
    assign num_sum = {1'b0, pb_reg} + {1'b0, pl_reg} + {{(N+1){1'b0}}, oa_a_reg >> 1};

    always_ff @(posedge aclk) begin
        if (en) begin
            pb_reg   <= base_c * base_a;
            pl_reg   <= layer_c * lw;
            oa_a_reg <= oa;
            num_reg  <= num_sum[2*N-1:0];
            oa_b_reg <= oa_a_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_div
            logic [N-1:0] r_in, l_in, q_in, d_in;
            logic [N:0]   r2, diff;
            if (k == 0) begin : g_first
                assign r_in = num_reg[2*N-1:N];
                assign l_in = num_reg[N-1:0];
                assign q_in = '0;
                assign d_in = oa_b_reg;
            end else begin : g_next
                assign r_in = rem_reg[k-1];
                assign l_in = low_reg[k-1];
                assign q_in = quo_reg[k-1];
                assign d_in = div_reg[k-1];
            end
            assign r2   = {r_in, l_in[N-1]};
            assign diff = r2 - {1'b0, d_in};
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (r2 >= {1'b0, d_in}) begin
                        rem_reg[k] <= diff[N-1:0];
                        quo_reg[k] <= {q_in[N-2:0], 1'b1};
                    end else begin
                        rem_reg[k] <= r2[N-1:0];
                        quo_reg[k] <= {q_in[N-2:0], 1'b0};
                    end
                    low_reg[k] <= {l_in[N-2:0], 1'b0};
                    div_reg[k] <= d_in;
                end
            end
        end
    endgenerate

    assign color = quo_reg[N-1];

endmodule

// ----- rtl/behind_mode_pixel_compositor_core.sv -----
// Paints a layer pixel behind a base pixel (destination-over) on a stream of
// RGBA pixels, with layer opacity optionally scaled by a per-pixel mask. One
// pixel per clock is taken and one result leaves per clock while results are
// taken; latency is set by the four-stage alpha path, the product and sum
// stages and the one-bit-per-stage dividers of the three color lanes.
// The whole pipeline holds while a finished result is not taken.
module behind_mode_pixel_compositor_core #(
    parameter int CHANNEL_BITS = bmpc_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bmpc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CHANNEL_BITS-1:0]           cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // base r,g,b,a, layer r,g,b,a, mask sample
    input  logic [((9*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out r,g,b,a
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
    output logic                              m_tlast
);
    import bmpc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int D  = N + 6;
    localparam int PW = 3*N + 1;
    localparam int OW = ((4*N+7)/8)*8;

    logic [N-1:0] opac_reg;
    logic         men_reg;
    logic         en;
    logic [D-1:0] vld_reg;
    logic [PW-1:0] pix_reg [D];
    logic [N-1:0]  oa_reg [N+2];
    logic [N-1:0]  lw, oa;
    logic [N-1:0]  col [3];
    logic          m_tvalid_reg, m_tlast_reg;
    logic [4*N-1:0] m_data_reg, m_data_next;
    logic [N-1:0]  oa_out;
    logic [PW-1:0] pix_out;

    // stage-four copies of base alpha and layer colors for the lanes
    logic [N-1:0] ba_d [4];
    logic [N-1:0] lc_d [4][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opac_reg <= '1;
            men_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_LAYER_OPACITY: opac_reg <= cfg_wdata;
                REG_MASK_ENABLE:   men_reg  <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    bmpc_alpha #(.CHANNEL_BITS(N)) u_alpha (
        .aclk          (aclk),
        .en            (en),
        .layer_opacity (opac_reg),
        .mask_enable   (men_reg),
        .base_alpha    (s_tdata[4*N-1:3*N]),
        .layer_alpha   (s_tdata[8*N-1:7*N]),
        .mask_sample   (s_tdata[9*N-1:8*N]),
        .lw            (lw),
        .oa            (oa)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            bmpc_lane #(.CHANNEL_BITS(N)) u_lane (
                .aclk    (aclk),
                .en      (en),
                .base_c  (pix_reg[3][c*N +: N]),
                .base_a  (ba_d[3]),
                .layer_c (lc_d[3][c]),
                .lw      (lw),
                .oa      (oa),
                .color   (col[c])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg[0] <= {s_tlast, s_tdata[3*N-1:0]};
            ba_d[0]    <= s_tdata[4*N-1:3*N];
            for (int j = 0; j < 3; j++) begin
                lc_d[0][j] <= s_tdata[(4+j)*N +: N];
            end
            for (int i = 1; i < D; i++) begin
                pix_reg[i] <= pix_reg[i-1];
            end
            for (int i = 1; i < 4; i++) begin
                ba_d[i] <= ba_d[i-1];
                lc_d[i] <= lc_d[i-1];
            end
            oa_reg[0] <= oa;
            for (int i = 1; i < N + 2; i++) begin
                oa_reg[i] <= oa_reg[i-1];
            end
        end
    end

    assign oa_out  = oa_reg[N+1];
    assign pix_out = pix_reg[D-1];

    always_comb begin
        if (oa_out == '0) begin
            m_data_next = {{N{1'b0}}, pix_out[3*N-1:0]};
        end else begin
            m_data_next = {oa_out, col[2], col[1], col[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[D-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[D-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg  <= m_data_next;
            m_tlast_reg <= pix_out[3*N];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = OW'(m_data_reg);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted pixel missing from pipeline");

endmodule
